/* rtl/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Shared types, codes and command tables for the SPI-mode SD host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

   localparam int MAX_BLOCK_BYTES_DEF = 4096;

   localparam int BLOCK_LENGTH_W = 13;
   localparam int INIT_DUMMY_W   = 8;
   localparam int CSR_DATA_W     = 13;

   localparam logic [BLOCK_LENGTH_W-1:0] BLOCK_LENGTH_RST = 13'd512;
   localparam logic [INIT_DUMMY_W-1:0]   INIT_DUMMY_RST   = 8'd76;

   // register indexes
   localparam logic CSR_BLOCK_LENGTH = 1'b0;
   localparam logic CSR_INIT_DUMMY   = 1'b1;

   // request function codes
   localparam logic [1:0] FUNC_INIT = 2'd0;
   localparam logic [1:0] FUNC_READ = 2'd1;
   localparam logic [1:0] FUNC_BYTE = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_BUSY       = 2'd0;
   localparam logic [1:0] STATUS_READY      = 2'd1;
   localparam logic [1:0] STATUS_INIT_ERR   = 2'd2;
   localparam logic [1:0] STATUS_BLOCK_DONE = 2'd3;

   // command selects for the command table
   localparam logic [1:0] CMD_SEL_GO_IDLE = 2'd0;
   localparam logic [1:0] CMD_SEL_IF_COND = 2'd1;
   localparam logic [1:0] CMD_SEL_APP     = 2'd2;
   localparam logic [1:0] CMD_SEL_OP_COND = 2'd3;

   localparam logic [7:0] BYTE_IDLE     = 8'hFF;
   localparam logic [7:0] DATA_TOKEN    = 8'hFE;
   localparam logic [7:0] CMD17_OPCODE  = 8'h51;
   localparam logic [7:0] CMD17_CRC     = 8'h01;
   localparam logic [7:0] IF_COND_CHECK = 8'hAA;
   localparam logic [7:0] R1_IDLE       = 8'h01;
   localparam logic [7:0] R1_READY      = 8'h00;
   localparam logic [7:0] ECHO_VOLTAGE  = 8'h01;

   localparam int CMD_BYTES = 6;

   // position of captured response bytes in the command byte count
   localparam int RESP_SECOND_IDX = CMD_BYTES + 1;
   localparam int RESP_FIFTH_IDX  = CMD_BYTES + 4;
   localparam int RESP_SIXTH_IDX  = CMD_BYTES + 5;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] block_address;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       chip_select_active;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       last_data;
      logic [1:0] status;
   } rsp_type;

   // command frames for CMD0, CMD8, CMD55 and CMD41
   function automatic logic [7:0] cmd_rom(input logic [1:0] sel, input logic [2:0] idx);
      logic [7:0] b;
      b = BYTE_IDLE;
      case (sel)
         CMD_SEL_GO_IDLE: begin
            case (idx)
               3'd0: b = 8'h40;
               3'd5: b = 8'h95;
               default: b = (idx < 3'd5) ? 8'h00 : BYTE_IDLE;
            endcase
         end
         CMD_SEL_IF_COND: begin
            case (idx)
               3'd0: b = 8'h48;
               3'd3: b = 8'h01;
               3'd4: b = 8'hAA;
               3'd5: b = 8'h87;
               default: b = (idx < 3'd5) ? 8'h00 : BYTE_IDLE;
            endcase
         end
         CMD_SEL_APP: begin
            case (idx)
               3'd0: b = 8'h77;
               3'd5: b = 8'h65;
               default: b = (idx < 3'd5) ? 8'h00 : BYTE_IDLE;
            endcase
         end
         default: begin
            case (idx)
               3'd0: b = 8'h69;
               3'd1: b = 8'h40;
               3'd5: b = 8'h77;
               default: b = (idx < 3'd5) ? 8'h00 : BYTE_IDLE;
            endcase
         end
      endcase
      return b;
   endfunction

   // index of the last response slot of each command
   function automatic logic [3:0] cmd_last_idx(input logic [1:0] sel);
      logic [3:0] n;
      case (sel)
         CMD_SEL_IF_COND: n = 4'd12;
         default:         n = 4'd8;
      endcase
      return n;
   endfunction

endpackage

/* rtl/sdspi_if.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface sdspi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] block_address;
   logic [7:0]  rx_byte;

   modport source (output valid, func, block_address, rx_byte, input ready);
   modport sink   (input valid, func, block_address, rx_byte, output ready);
endinterface

interface sdspi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       chip_select_active;
   logic       data_valid;
   logic [7:0] data_byte;
   logic       last_data;
   logic [1:0] status;

   modport source (output valid, tx_byte, chip_select_active, data_valid, data_byte,
                   last_data, status, input ready);
   modport sink   (input valid, tx_byte, chip_select_active, data_valid, data_byte,
                   last_data, status, output ready);
endinterface

/* rtl/sdspi_seq.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer core
// Phase state machine: decides the next byte, select level and status per word.
// ----------------------------------------------------------------------------
module sdspi_seq
   import sdspi_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  req_type                   req_word,
   input  logic [BLOCK_LENGTH_W-1:0] block_length,
   input  logic [INIT_DUMMY_W-1:0]   init_dummy_bytes,
   output logic                      has_result,
   output rsp_type                   rsp_word
);

   localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int CMP_W = (CNT_W > BLOCK_LENGTH_W) ? CNT_W : BLOCK_LENGTH_W;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DUMMY, PH_CMD0, PH_CMD8, PH_CMD55, PH_CMD41, PH_CMD17, PH_TOKEN, PH_DATA
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       resp_second_ff, resp_second_in;
   logic [7:0]       resp_fifth_ff, resp_fifth_in;
   logic [7:0]       resp_sixth_ff, resp_sixth_in;
   logic [31:0]      target_ff, target_in;

   logic [CNT_W-1:0] k1;
   logic [CNT_W-1:0] eff_len;
   logic [1:0]       cur_sel;
   logic             start;
   phase_type        start_phase;

   function automatic logic [1:0] sel_of(input phase_type p);
      logic [1:0] s;
      case (p)
         PH_CMD8:  s = CMD_SEL_IF_COND;
         PH_CMD55: s = CMD_SEL_APP;
         PH_CMD41: s = CMD_SEL_OP_COND;
         default:  s = CMD_SEL_GO_IDLE;
      endcase
      return s;
   endfunction

   assign k1      = count_ff + CNT_W'(1);
   assign cur_sel = sel_of(phase_ff);
   assign eff_len = (CMP_W'(block_length) > CMP_W'(MAX_BLOCK_BYTES)) ?
                    CNT_W'(MAX_BLOCK_BYTES) : CNT_W'(block_length);

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      resp_second_in = resp_second_ff;
      resp_fifth_in  = resp_fifth_ff;
      resp_sixth_in  = resp_sixth_ff;
      target_in      = target_ff;
      start          = 1'b0;
      start_phase    = PH_CMD0;
      has_result     = 1'b1;
      rsp_word       = '{tx_byte: BYTE_IDLE, chip_select_active: 1'b0, data_valid: 1'b0,
                         data_byte: 8'h00, last_data: 1'b0, status: STATUS_BUSY};

      case (req_word.func)
         FUNC_INIT: begin
            if (init_dummy_bytes != '0) begin
               phase_in = PH_DUMMY;
               count_in = '0;
            end else begin
               start = 1'b1;
            end
         end
         FUNC_READ: begin
            target_in = req_word.block_address;
            phase_in  = PH_CMD17;
            count_in  = '0;
            rsp_word.tx_byte            = CMD17_OPCODE;
            rsp_word.chip_select_active = 1'b1;
         end
         FUNC_BYTE: begin
            case (phase_ff)
               PH_DUMMY: begin
                  if (k1 < CNT_W'(init_dummy_bytes)) begin
                     count_in = k1;
                  end else begin
                     start = 1'b1;
                  end
               end
               PH_CMD0, PH_CMD8, PH_CMD55, PH_CMD41: begin
                  // capture response slots; CMD55 answers are ignored
                  if (phase_ff != PH_CMD55) begin
                     if (count_ff == CNT_W'(RESP_SECOND_IDX)) resp_second_in = req_word.rx_byte;
                     if (count_ff == CNT_W'(RESP_FIFTH_IDX))  resp_fifth_in  = req_word.rx_byte;
                     if (count_ff == CNT_W'(RESP_SIXTH_IDX))  resp_sixth_in  = req_word.rx_byte;
                  end
                  if (count_ff < CNT_W'(cmd_last_idx(cur_sel))) begin
                     count_in = k1;
                     rsp_word.chip_select_active = 1'b1;
                     if (k1 < CNT_W'(CMD_BYTES)) begin
                        rsp_word.tx_byte = cmd_rom(cur_sel, k1[2:0]);
                     end
                  end else begin
                     case (phase_ff)
                        PH_CMD0: begin
                           start       = 1'b1;
                           start_phase = (resp_second_in == R1_IDLE) ? PH_CMD8 : PH_CMD0;
                        end
                        PH_CMD8: begin
                           if (resp_second_in != R1_IDLE || resp_fifth_in != ECHO_VOLTAGE ||
                               resp_sixth_in != IF_COND_CHECK) begin
                              phase_in        = PH_IDLE;
                              count_in        = '0;
                              rsp_word.status = STATUS_INIT_ERR;
                           end else begin
                              start       = 1'b1;
                              start_phase = PH_CMD55;
                           end
                        end
                        PH_CMD55: begin
                           start       = 1'b1;
                           start_phase = PH_CMD41;
                        end
                        default: begin
                           if (resp_second_in == R1_READY) begin
                              phase_in        = PH_IDLE;
                              count_in        = '0;
                              rsp_word.status = STATUS_READY;
                           end else begin
                              start       = 1'b1;
                              start_phase = PH_CMD55;
                           end
                        end
                     endcase
                  end
               end
               PH_CMD17: begin
                  rsp_word.chip_select_active = 1'b1;
                  if (k1 < CNT_W'(CMD_BYTES)) begin
                     count_in = k1;
                     case (k1[2:0])
                        3'd1:    rsp_word.tx_byte = target_ff[31:24];
                        3'd2:    rsp_word.tx_byte = target_ff[23:16];
                        3'd3:    rsp_word.tx_byte = target_ff[15:8];
                        3'd4:    rsp_word.tx_byte = target_ff[7:0];
                        default: rsp_word.tx_byte = CMD17_CRC;
                     endcase
                  end else begin
                     phase_in = PH_TOKEN;
                     count_in = '0;
                  end
               end
               PH_TOKEN: begin
                  rsp_word.chip_select_active = 1'b1;
                  if (req_word.rx_byte == DATA_TOKEN) begin
                     count_in = '0;
                     if (eff_len == '0) begin
                        phase_in                    = PH_IDLE;
                        rsp_word.chip_select_active = 1'b0;
                        rsp_word.status             = STATUS_BLOCK_DONE;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  rsp_word.data_valid = 1'b1;
                  rsp_word.data_byte  = req_word.rx_byte;
                  if (k1 >= eff_len) begin
                     phase_in           = PH_IDLE;
                     count_in           = '0;
                     rsp_word.last_data = 1'b1;
                     rsp_word.status    = STATUS_BLOCK_DONE;
                  end else begin
                     count_in                    = k1;
                     rsp_word.chip_select_active = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end
            endcase
         end
         default: begin
            // unused function: no response, state untouched
            has_result = 1'b0;
         end
      endcase

      if (start) begin
         phase_in                    = start_phase;
         count_in                    = '0;
         rsp_word.tx_byte            = cmd_rom(sel_of(start_phase), 3'd0);
         rsp_word.chip_select_active = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         count_ff       <= '0;
         resp_second_ff <= BYTE_IDLE;
         resp_fifth_ff  <= BYTE_IDLE;
         resp_sixth_ff  <= BYTE_IDLE;
         target_ff      <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         resp_second_ff <= resp_second_in;
         resp_fifth_ff  <= resp_fifth_in;
         resp_sixth_ff  <= resp_sixth_in;
         target_ff      <= target_in;
      end
   end

endmodule

/* rtl/sd_spi_init_and_block_read.sv */
// ----------------------------------------------------------------------------
// SD card SPI-mode init and single-block read sequencer
// Byte-driven host sequencer with request/response channels and a CSR port.
// ----------------------------------------------------------------------------
// Each request word is one step: start init, start a block read, or the byte
// received from the card in the last exchange. Each step except the unused
// function code yields one response word with the next byte to send, the
// select level, any captured data byte and a status code. Words pass through
// a request register and then a response register before a response is
// offered, and one request is taken every cycle while the response side
// keeps up; a stall on the response side holds both registers. Write
// block_length and init_dummy_bytes only while no step is in flight. There
// are no timeouts: the card polling loops run until it answers.
// ----------------------------------------------------------------------------
module sd_spi_init_and_block_read
   import sdspi_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sdspi_req_if.sink             req,
   sdspi_rsp_if.source           rsp,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                      req_valid_ff;
   req_type                   req_word_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_word_ff;
   logic [BLOCK_LENGTH_W-1:0] block_length_ff;
   logic [INIT_DUMMY_W-1:0]   init_dummy_ff;

   logic    advance;
   logic    has_result;
   rsp_type rsp_word_in;

   // advance the held word when the response register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;

   sdspi_seq #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .req_word         (req_word_ff),
      .block_length     (block_length_ff),
      .init_dummy_bytes (init_dummy_ff),
      .has_result       (has_result),
      .rsp_word         (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         block_length_ff <= BLOCK_LENGTH_RST;
         init_dummy_ff   <= INIT_DUMMY_RST;
      end else begin
         if (req.ready) begin
            req_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= has_result;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_LENGTH: block_length_ff <= csr_wdata[BLOCK_LENGTH_W-1:0];
               CSR_INIT_DUMMY:   init_dummy_ff   <= csr_wdata[INIT_DUMMY_W-1:0];
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_word_ff <= '{func: req.func, block_address: req.block_address,
                          rx_byte: req.rx_byte};
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.tx_byte            = rsp_word_ff.tx_byte;
   assign rsp.chip_select_active = rsp_word_ff.chip_select_active;
   assign rsp.data_valid         = rsp_word_ff.data_valid;
   assign rsp.data_byte          = rsp_word_ff.data_byte;
   assign rsp.last_data          = rsp_word_ff.last_data;
   assign rsp.status             = rsp_word_ff.status;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer testbench
// Plays an SD card in SPI mode against the init and block-read sequencer.
// A behavioural model predicts every response word, and each response is
// compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import sdspi_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int BLOCK_CAP = MAX_BLOCK_BYTES_DEF;
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_DUMMY, SEQ_CMD0, SEQ_CMD8, SEQ_CMD55, SEQ_CMD41,
      SEQ_CMD17, SEQ_TOKEN, SEQ_DATA
   } seq_phase_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sdspi_req_if req_ch ();
   sdspi_rsp_if rsp_ch ();

   sd_spi_init_and_block_read i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // sequencer model state and registers
   seq_phase_type seq = SEQ_IDLE;
   int          seq_count = 0;
   logic [7:0]  reply_b1 = BYTE_IDLE;
   logic [7:0]  reply_b4 = BYTE_IDLE;
   logic [7:0]  reply_b5 = BYTE_IDLE;
   logic [31:0] target_lba = '0;
   logic [12:0] cfg_block_len = BLOCK_LENGTH_RST;
   logic [7:0]  cfg_dummy = INIT_DUMMY_RST;

   rsp_type exchanges[$];
   int mismatches = 0;
   int src_idle_pct = 0;
   int snk_stall_pct = 0;
   int hold_left = 0;

   function automatic logic [7:0] frame_byte(seq_phase_type p, int idx);
      logic [47:0] frame;
      case (p)
         SEQ_CMD0:  frame = 48'h40_00_00_00_00_95;
         SEQ_CMD8:  frame = 48'h48_00_00_01_AA_87;
         SEQ_CMD55: frame = 48'h77_00_00_00_00_65;
         SEQ_CMD41: frame = 48'h69_40_00_00_00_77;
         SEQ_CMD17: frame = {CMD17_OPCODE, target_lba, CMD17_CRC};
         default:   frame = {6{BYTE_IDLE}};
      endcase
      if (idx >= 6) return BYTE_IDLE;
      return frame[47 - 8*idx -: 8];
   endfunction

   function automatic logic [7:0] open_frame(seq_phase_type p);
      seq = p;
      seq_count = 0;
      return frame_byte(p, 0);
   endfunction

   function automatic void park();
      seq = SEQ_IDLE;
      seq_count = 0;
   endfunction

   // advance the model by one word and return the response it should give
   function automatic rsp_type next_exchange(req_type w);
      rsp_type r;
      int k;
      int frame_len;
      int blen;
      r = '0;
      r.tx_byte = BYTE_IDLE;
      r.chip_select_active = 1'b1;
      k = seq_count;
      blen = (cfg_block_len > BLOCK_CAP) ? BLOCK_CAP : int'(cfg_block_len);
      case (w.func)
         FUNC_INIT: begin
            if (cfg_dummy != 0) begin
               seq = SEQ_DUMMY;
               seq_count = 0;
               r.chip_select_active = 1'b0;
            end else begin
               r.tx_byte = open_frame(SEQ_CMD0);
            end
         end
         FUNC_READ: begin
            target_lba = w.block_address;
            r.tx_byte = open_frame(SEQ_CMD17);
         end
         default: begin
            case (seq)
               SEQ_DUMMY: begin
                  if (k + 1 < cfg_dummy) begin
                     seq_count = k + 1;
                     r.chip_select_active = 1'b0;
                  end else begin
                     r.tx_byte = open_frame(SEQ_CMD0);
                  end
               end
               SEQ_CMD0, SEQ_CMD8, SEQ_CMD55, SEQ_CMD41: begin
                  frame_len = (seq == SEQ_CMD8) ? 13 : 9;
                  // response slot r arrives at count 6 + r; CMD55 answers are dropped
                  if (seq != SEQ_CMD55) begin
                     if (k == 7) reply_b1 = w.rx_byte;
                     else if (k == 10) reply_b4 = w.rx_byte;
                     else if (k == 11) reply_b5 = w.rx_byte;
                  end
                  if (k + 1 < frame_len) begin
                     seq_count = k + 1;
                     r.tx_byte = frame_byte(seq, k + 1);
                  end else begin
                     case (seq)
                        SEQ_CMD0: begin
                           r.tx_byte = open_frame(reply_b1 == R1_IDLE ? SEQ_CMD8 : SEQ_CMD0);
                        end
                        SEQ_CMD8: begin
                           if (reply_b1 != R1_IDLE || reply_b4 != ECHO_VOLTAGE ||
                               reply_b5 != IF_COND_CHECK) begin
                              park();
                              r.chip_select_active = 1'b0;
                              r.status = STATUS_INIT_ERR;
                           end else begin
                              r.tx_byte = open_frame(SEQ_CMD55);
                           end
                        end
                        SEQ_CMD55: begin
                           r.tx_byte = open_frame(SEQ_CMD41);
                        end
                        default: begin
                           if (reply_b1 == R1_READY) begin
                              park();
                              r.chip_select_active = 1'b0;
                              r.status = STATUS_READY;
                           end else begin
                              r.tx_byte = open_frame(SEQ_CMD55);
                           end
                        end
                     endcase
                  end
               end
               SEQ_CMD17: begin
                  if (k + 1 < 6) begin
                     seq_count = k + 1;
                     r.tx_byte = frame_byte(SEQ_CMD17, k + 1);
                  end else begin
                     seq = SEQ_TOKEN;
                     seq_count = 0;
                  end
               end
               SEQ_TOKEN: begin
                  if (w.rx_byte == DATA_TOKEN) begin
                     if (blen == 0) begin
                        park();
                        r.chip_select_active = 1'b0;
                        r.status = STATUS_BLOCK_DONE;
                     end else begin
                        seq = SEQ_DATA;
                        seq_count = 0;
                     end
                  end
               end
               SEQ_DATA: begin
                  r.data_valid = 1'b1;
                  r.data_byte = w.rx_byte;
                  if (k + 1 >= blen) begin
                     r.last_data = 1'b1;
                     park();
                     r.chip_select_active = 1'b0;
                     r.status = STATUS_BLOCK_DONE;
                  end else begin
                     seq_count = k + 1;
                  end
               end
               default: begin
                  park();
                  r.chip_select_active = 1'b0;
               end
            endcase
         end
      endcase
      return r;
   endfunction

   // a plausible card answer for the exchange in progress, now and then noise
   function automatic logic [7:0] card_reply();
      logic [7:0] noise;
      int roll;
      noise = 8'($urandom);
      roll = $urandom_range(99);
      case (seq)
         SEQ_CMD0: if (seq_count == 7 && roll < 70) return R1_IDLE;
         SEQ_CMD8: begin
            if (seq_count == 7 && roll < 85) return R1_IDLE;
            if (seq_count == 10 && roll < 85) return ECHO_VOLTAGE;
            if (seq_count == 11 && roll < 85) return IF_COND_CHECK;
         end
         SEQ_CMD41: if (seq_count == 7) return (roll < 50) ? R1_READY : R1_IDLE;
         SEQ_TOKEN: if (roll < 35) return DATA_TOKEN;
         default: ;
      endcase
      return noise;
   endfunction

   function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (exchanges.size() == 0) begin
            $display("%0t: unexpected response word: expected none, actual tx %0h status %0d",
                     $time, rsp_ch.tx_byte, rsp_ch.status);
            mismatches++;
         end else begin
            want = exchanges.pop_front();
            check_field("tx_byte", want.tx_byte, rsp_ch.tx_byte);
            check_field("chip_select_active", 8'(want.chip_select_active),
                        8'(rsp_ch.chip_select_active));
            check_field("data_valid", 8'(want.data_valid), 8'(rsp_ch.data_valid));
            check_field("data_byte", want.data_byte, rsp_ch.data_byte);
            check_field("last_data", 8'(want.last_data), 8'(rsp_ch.last_data));
            check_field("status", 8'(want.status), 8'(rsp_ch.status));
         end
      end
   end

   // response side: random stalls, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= snk_stall_pct);
      end
   end

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < src_idle_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.func = w.func;
      req_ch.block_address = w.block_address;
      req_ch.rx_byte = w.rx_byte;
      do @(posedge clock); while (!req_ch.ready);
      if (w.func != FUNC_UNUSED) exchanges.push_back(next_exchange(w));
   endtask

   task automatic issue(input logic [1:0] f, input logic [31:0] addr);
      req_type w;
      w.func = f;
      w.block_address = addr;
      w.rx_byte = 8'($urandom);
      send_word(w);
   endtask

   task automatic feed(input logic [7:0] rx);
      req_type w;
      w.func = FUNC_BYTE;
      w.block_address = $urandom;
      w.rx_byte = rx;
      send_word(w);
   endtask

   task automatic feed_while(input seq_phase_type p);
      while (seq == p) feed(8'($urandom));
   endtask

   // answer one command frame with the given R1, echo and check-pattern bytes
   task automatic feed_frame(input logic [7:0] r1, input logic [7:0] r4, input logic [7:0] r5);
      do begin
         if (seq_count == 7) feed(r1);
         else if (seq_count == 10) feed(r4);
         else if (seq_count == 11) feed(r5);
         else feed(BYTE_IDLE);
      end while (seq_count != 0);
   endtask

   // drop valid and wait for every outstanding response, then a little more
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (exchanges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_BLOCK_LENGTH) cfg_block_len = val;
      else cfg_dummy = val[7:0];
   endtask

   task automatic run_traffic(input int n_words);
      req_type w;
      int done;
      int pick;
      done = 0;
      while (done < n_words) begin
         w.block_address = $urandom;
         w.rx_byte = card_reply();
         pick = $urandom_range(99);
         if (seq == SEQ_IDLE)
            w.func = (pick < 45) ? FUNC_READ : (pick < 75) ? FUNC_INIT :
                     (pick < 95) ? FUNC_BYTE : FUNC_UNUSED;
         else
            w.func = (pick < 2) ? FUNC_INIT : (pick < 4) ? FUNC_READ :
                     (pick < 6) ? FUNC_UNUSED : FUNC_BYTE;
         if (w.func != FUNC_UNUSED) done++;
         send_word(w);
      end
   endtask

   task automatic test_idle_requests();
      feed(8'h00);
      feed(8'hFF);
      issue(FUNC_UNUSED, 32'hFFFF_FFFF);
      feed(DATA_TOKEN);
   endtask

   task automatic test_read_before_init();
      // reset block length first, then an empty block, then a single byte
      issue(FUNC_READ, 32'hFFFF_FFFF);
      feed_while(SEQ_CMD17);
      feed(BYTE_IDLE);
      feed(DATA_TOKEN);
      repeat (8) feed(8'($urandom));
      settle();
      write_reg(CSR_BLOCK_LENGTH, 13'd0);
      issue(FUNC_READ, 32'h0000_0000);
      feed_while(SEQ_CMD17);
      feed(BYTE_IDLE);
      feed(8'h00);
      feed(DATA_TOKEN);
      settle();
      write_reg(CSR_BLOCK_LENGTH, 13'd1);
      issue(FUNC_READ, 32'h8000_0001);
      feed_while(SEQ_CMD17);
      feed(DATA_TOKEN);
      feed(8'h5A);
   endtask

   task automatic test_init_sequence();
      // reset dummy count, CMD0 retried, then a bad check pattern
      issue(FUNC_INIT, $urandom);
      feed_while(SEQ_DUMMY);
      feed_frame(BYTE_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, ECHO_VOLTAGE, 8'h55);
      settle();
      write_reg(CSR_INIT_DUMMY, 13'd0);
      issue(FUNC_INIT, $urandom);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(8'h05, ECHO_VOLTAGE, IF_COND_CHECK);
      issue(FUNC_INIT, $urandom);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, 8'h00, IF_COND_CHECK);
      // good path, with one CMD55/CMD41 loop before the card is ready
      issue(FUNC_INIT, $urandom);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, ECHO_VOLTAGE, IF_COND_CHECK);
      feed_frame(R1_READY, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_READY, BYTE_IDLE, BYTE_IDLE);
   endtask

   task automatic test_restart_while_busy();
      settle();
      write_reg(CSR_INIT_DUMMY, 13'd3);
      issue(FUNC_INIT, $urandom);
      feed(8'hFF);
      issue(FUNC_READ, 32'h0F0F_F0F0);
      feed(8'($urandom));
      issue(FUNC_UNUSED, $urandom);
      feed(8'($urandom));
      issue(FUNC_INIT, $urandom);
      feed_while(SEQ_DUMMY);
      repeat (4) feed(BYTE_IDLE);
      issue(FUNC_READ, 32'h1234_5678);
      feed_while(SEQ_CMD17);
      feed(DATA_TOKEN);
      feed_while(SEQ_DATA);
   endtask

   task automatic test_dummy_extremes();
      settle();
      write_reg(CSR_INIT_DUMMY, 13'd255);
      issue(FUNC_INIT, $urandom);
      feed_while(SEQ_DUMMY);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, 8'h02, IF_COND_CHECK);
      settle();
      write_reg(CSR_INIT_DUMMY, 13'd1);
      issue(FUNC_INIT, $urandom);
      feed_while(SEQ_DUMMY);
      feed_frame(8'h00, BYTE_IDLE, BYTE_IDLE);
      feed_frame(R1_IDLE, BYTE_IDLE, BYTE_IDLE);
      feed_frame(BYTE_IDLE, BYTE_IDLE, BYTE_IDLE);
   endtask

   task automatic test_block_cap();
      // length beyond the maximum: the block runs on past the first bytes
      settle();
      write_reg(CSR_BLOCK_LENGTH, 13'h1FFF);
      issue(FUNC_READ, $urandom);
      feed_while(SEQ_CMD17);
      feed(DATA_TOKEN);
      repeat (8) feed(8'($urandom));
   endtask

   task automatic test_backpressure();
      settle();
      write_reg(CSR_BLOCK_LENGTH, 13'd4);
      write_reg(CSR_INIT_DUMMY, 13'd0);
      src_idle_pct = 0;
      snk_stall_pct = 0;
      hold_left = 80;
      run_traffic(40);
   endtask

   task automatic traffic_phase(input int src, input int snk, input logic [12:0] blen,
                                input logic [7:0] dummy, input int n_words);
      settle();
      write_reg(CSR_BLOCK_LENGTH, blen);
      write_reg(CSR_INIT_DUMMY, 13'(dummy));
      src_idle_pct = src;
      snk_stall_pct = snk;
      run_traffic(n_words);
   endtask

   task automatic test_random_traffic();
      traffic_phase(0, 0, 13'd1, 8'd0, 25);
      traffic_phase(71, 0, 13'($urandom_range(12, 2)), 8'd1, 25);
      traffic_phase(0, 71, 13'd0, 8'd2, 25);
      traffic_phase(28, 28, 13'($urandom_range(16, 1)), 8'd4, 25);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BLOCK_LENGTH;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_BYTE;
      req_ch.block_address = '0;
      req_ch.rx_byte = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_idle_requests();
      test_read_before_init();
      test_init_sequence();
      test_restart_while_busy();
      test_dummy_extremes();
      test_block_cap();
      test_backpressure();
      test_random_traffic();
      settle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
